### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the five-way key debounce core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fwkd_pkg.sv
// Package for the five-way key debounce core: widths, register indexes,
// reset values, the per-key control struct and the settle test.
// No dependencies.
`default_nettype none
package fwkd_pkg;

	localparam int TIME_MAX     = 32;
	localparam int TIME_BITS_DEF = 32;
	localparam int NUM_DIR      = 4;
	localparam int NUM_KEY      = 5;
	localparam int NUM_EVT      = 6;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef struct packed {
		logic step;
		logic lvl;
	} key_ctl_t;

	function automatic logic key_settled(
		input logic                changed,
		input logic [TIME_MAX-1:0] held,
		input logic [CFG_W-1:0]    dly
	);
		logic ok;
		if (changed) begin
			ok = (dly == '0);
		end else begin
			ok = (held >= TIME_MAX'(dly));
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

### rtl/fwkd_dir_key.sv
// One direction key: raw level tracking, debounce and once-per-press event.
// Depends on fwkd_pkg.
`default_nettype none
module fwkd_dir_key #(
	parameter int TIME_BITS = fwkd_pkg::TIME_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fwkd_pkg::key_ctl_t           ctl,
	input  wire [TIME_BITS-1:0]          now,
	input  wire [fwkd_pkg::CFG_W-1:0]    debounce,
	output logic                         evt
);
	import fwkd_pkg::*;

	logic                 raw_q;
	logic                 stable_q;
	logic                 rep_q;
	logic [TIME_BITS-1:0] chg_q;
	logic [TIME_BITS-1:0] held;
	logic                 settled;
	logic                 stable_d;
	logic                 rep_d;

	assign held    = now - chg_q;
	assign settled = key_settled(ctl.lvl != raw_q, TIME_MAX'(held), debounce);

	always_comb begin
		stable_d = stable_q;
		rep_d    = rep_q;
		evt      = 1'b0;
		if (settled) begin
			if (ctl.lvl != stable_q) begin
				stable_d = ctl.lvl;
				rep_d    = 1'b0;
			end
			if (stable_d && !rep_d) begin
				rep_d = 1'b1;
				evt   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			stable_q <= 1'b0;
			rep_q    <= 1'b0;
			chg_q    <= '0;
		end else if (ctl.step) begin
			raw_q    <= ctl.lvl;
			stable_q <= stable_d;
			rep_q    <= rep_d;
			if (ctl.lvl != raw_q) begin
				chg_q <= now;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/fwkd_centre_key.sv
// Centre key: debounce, select on a short release, back once on a long hold.
// Depends on fwkd_pkg.
`default_nettype none
module fwkd_centre_key #(
	parameter int TIME_BITS = fwkd_pkg::TIME_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fwkd_pkg::key_ctl_t           ctl,
	input  wire [TIME_BITS-1:0]          now,
	input  wire [fwkd_pkg::CFG_W-1:0]    debounce,
	input  wire [fwkd_pkg::CFG_W-1:0]    long_press,
	output logic                         sel_evt,
	output logic                         back_evt
);
	import fwkd_pkg::*;

	logic                 raw_q;
	logic                 stable_q;
	logic                 long_q;
	logic [TIME_BITS-1:0] chg_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] held;
	logic [TIME_BITS-1:0] press_held;
	logic                 settled;
	logic                 changed;
	logic                 rise;
	logic                 stable_d;
	logic                 long_d;

	assign held       = now - chg_q;
	assign settled    = key_settled(ctl.lvl != raw_q, TIME_MAX'(held), debounce);
	assign changed    = settled && (ctl.lvl != stable_q);
	assign rise       = changed && ctl.lvl;
	assign press_held = rise ? '0 : (now - start_q);

	always_comb begin
		stable_d = stable_q;
		long_d   = long_q;
		sel_evt  = 1'b0;
		back_evt = 1'b0;
		if (settled) begin
			if (changed) begin
				sel_evt  = !ctl.lvl && stable_q && !long_q;
				stable_d = ctl.lvl;
				long_d   = 1'b0;
			end
			if (stable_d && !long_d &&
				(TIME_MAX'(press_held) >= TIME_MAX'(long_press))) begin
				long_d   = 1'b1;
				back_evt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			stable_q <= 1'b0;
			long_q   <= 1'b0;
			chg_q    <= '0;
			start_q  <= '0;
		end else if (ctl.step) begin
			raw_q    <= ctl.lvl;
			stable_q <= stable_d;
			long_q   <= long_d;
			if (ctl.lvl != raw_q) begin
				chg_q <= now;
			end
			if (rise) begin
				start_q <= now;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/five_way_key_debounce_long_press_core.sv
// Five-way key debounce core with centre long press.
// Input poll: s_tvalid/s_tready/s_tdata; one poll word carries five key
// levels (1 = pressed) and a millisecond timestamp.
// Output: m_tvalid/m_tready/m_tdata; one flag word per poll, in poll order,
// all flags zero when nothing fires.
// Configuration: cfg_we/cfg_idx/cfg_wdata, index 0 debounce time,
// index 1 long-press time, both in milliseconds; write only while idle.
// Path: an accepted poll waits in the input register, then its flags land
// in the output register, which drives m_tvalid and m_tdata.
// Throughput: one poll per cycle while m_tready is high; each key updates
// its state in the cycle its poll leaves the input register.
// Reset: all key state clears to released with timestamps zero, debounce
// time 50 and long-press time 1000; both channels come up empty.
// Stall: while m_tready is low the output word holds, the input register
// keeps one more poll, and s_tready drops only when both are full.
// Depends on fwkd_pkg, fwkd_dir_key, fwkd_centre_key and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module five_way_key_debounce_long_press_core #(
	parameter int TIME_BITS = fwkd_pkg::TIME_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [fwkd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [fwkd_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// up_pressed, down_pressed, left_pressed, right_pressed, center_pressed,
	// now_ms[31:0], zero pad
	input  wire [fwkd_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// up_event, down_event, left_event, right_event, select_event,
	// back_event, zero pad
	output logic [fwkd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import fwkd_pkg::*;

	logic [CFG_W-1:0]     debounce_q;
	logic [CFG_W-1:0]     long_press_q;
	logic                 v_s1;
	logic [NUM_KEY-1:0]   lvl_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 out_v_q;
	logic [NUM_EVT-1:0]   evt_q;
	logic [NUM_EVT-1:0]   evt;
	logic                 advance;
	key_ctl_t             ctl [NUM_KEY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				REG_LONG_PRESS: long_press_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			lvl_s1 <= s_tdata[NUM_KEY-1:0];
			now_s1 <= s_tdata[NUM_KEY +: TIME_BITS];
		end
	end

	for (genvar k = 0; k < NUM_KEY; k++) begin : g_ctl
		assign ctl[k].step = advance;
		assign ctl[k].lvl  = lvl_s1[k];
	end

	for (genvar k = 0; k < NUM_DIR; k++) begin : g_dir
		fwkd_dir_key #(.TIME_BITS(TIME_BITS)) u_dir (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[k]),
			.now      (now_s1),
			.debounce (debounce_q),
			.evt      (evt[k])
		);
	end

	fwkd_centre_key #(.TIME_BITS(TIME_BITS)) u_centre (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl[NUM_DIR]),
		.now        (now_s1),
		.debounce   (debounce_q),
		.long_press (long_press_q),
		.sel_evt    (evt[NUM_DIR]),
		.back_evt   (evt[NUM_DIR+1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			evt_q <= evt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_TDATA_W-NUM_EVT){1'b0}}, evt_q};

	`AST_SAME(a_sel_back_excl, m_tvalid, !(m_tdata[NUM_DIR] && m_tdata[NUM_DIR+1]), "select and back in one word")
	`AST_NEXT(a_accept_fills, s_tvalid && s_tready, v_s1, "accepted poll lost before input register")
	`AST_SAME(a_no_overrun, out_v_q && !m_tready, !advance, "output word overwritten while stalled")

endmodule
`default_nettype wire
